// File: rtl/owfpp_pkg.sv
// owfpp_pkg: shared constants, types and helpers for the overwrite fifo packet packer
// depends on nothing; used by the top level and its port checker
`default_nettype none

package owfpp_pkg;

   localparam int DEPTH = 16;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam int KIND_W   = 3;
   localparam int MODE_W   = 8;
   localparam int KEEP_W   = 5;
   localparam int IDENT_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 4;
   localparam int HDR_W    = KIND_W + KEEP_W + IDENT_W;
   localparam int RDG_W    = 4 * VALUE_W;

   localparam logic [LIMIT_W-1:0] TYPE_LIMIT_RESET = LIMIT_W'(8);

   typedef enum logic {
      OP_REPORT = 1'b0,
      OP_PICK   = 1'b1
   } op_type;

   // ring pointer advance, safe for a depth that is not a power of two
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/overwrite_fifo_packet_packer.sv
// overwrite_fifo_packet_packer: overwrite-oldest sensor report ring with 11-byte packet output
// depends on owfpp_pkg (depth, field widths, op codes, pointer helper)
// a pick shows its packet on rsp_* for one cycle, the cycle after it is accepted
// throughput: one item per cycle, reports and picks alike; busy stays low
// the ring is one read port and one write port of two synchronous memories with registered reads
// reset (synchronous, active high) empties the ring, zeroes the sequence, sets type_limit to 8
`default_nettype none

module overwrite_fifo_packet_packer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_op,
   input  wire logic [owfpp_pkg::KIND_W-1:0]   req_sensor_kind,
   input  wire logic [owfpp_pkg::MODE_W-1:0]   req_sensor_mode,
   input  wire logic [owfpp_pkg::IDENT_W-1:0]  req_sensor_ident,
   input  wire logic signed [owfpp_pkg::VALUE_W-1:0] req_value_a,
   input  wire logic signed [owfpp_pkg::VALUE_W-1:0] req_value_b,
   input  wire logic signed [owfpp_pkg::VALUE_W-1:0] req_value_c,
   input  wire logic signed [owfpp_pkg::VALUE_W-1:0] req_value_d,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [owfpp_pkg::LIMIT_W-1:0]  csr_data,
   output logic                                rsp_strobe,
   output logic                                rsp_ok,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_seq_byte,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_kind_mode_byte,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_ident_byte,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_a_low,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_a_high,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_b_low,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_b_high,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_c_low,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_c_high,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_d_low,
   output logic [owfpp_pkg::BYTE_W-1:0]        rsp_d_high
);

   logic [owfpp_pkg::HDR_W-1:0]   header_mem  [owfpp_pkg::DEPTH];
   logic [owfpp_pkg::RDG_W-1:0]   reading_mem [owfpp_pkg::DEPTH];

   logic [owfpp_pkg::PTR_W-1:0]   write_ptr_ff, write_ptr_in;
   logic [owfpp_pkg::PTR_W-1:0]   read_ptr_ff, read_ptr_in;
   logic [owfpp_pkg::CNT_W-1:0]   fill_count_ff, fill_count_in;
   logic [owfpp_pkg::BYTE_W-1:0]  seq_ff, seq_in;
   logic [owfpp_pkg::LIMIT_W-1:0] type_limit_ff, type_limit_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_ok_ff, rsp_ok_in;
   logic [owfpp_pkg::BYTE_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic [owfpp_pkg::HDR_W-1:0]   hdr_rd_ff;
   logic [owfpp_pkg::RDG_W-1:0]   rdg_rd_ff;

   logic accept;
   logic is_pick;
   logic report_we;
   logic pick_re;
   logic ring_full;
   logic ring_empty;
   logic kind_ok;
   logic [owfpp_pkg::HDR_W-1:0] hdr_wr;
   logic [owfpp_pkg::RDG_W-1:0] rdg_wr;
   logic [owfpp_pkg::BYTE_W-1:0] byte_out [8];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign accept     = start && !busy;
   assign is_pick    = (owfpp_pkg::op_type'(req_op) == owfpp_pkg::OP_PICK);
   assign ring_full  = (fill_count_ff == owfpp_pkg::CNT_W'(owfpp_pkg::DEPTH));
   assign ring_empty = (fill_count_ff == '0);
   assign kind_ok    = ({1'b0, req_sensor_kind} < type_limit_ff);
   assign report_we  = accept && !is_pick && kind_ok;
   assign pick_re    = accept && is_pick && !ring_empty;

   assign hdr_wr = {req_sensor_kind, req_sensor_mode[owfpp_pkg::KEEP_W-1:0], req_sensor_ident};
   assign rdg_wr = {req_value_d, req_value_c, req_value_b, req_value_a};

   always_comb begin
      write_ptr_in  = write_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      fill_count_in = fill_count_ff;
      seq_in        = seq_ff;
      type_limit_in = type_limit_ff;
      rsp_strobe_in = accept && is_pick;
      rsp_ok_in     = pick_re;
      rsp_seq_in    = seq_ff;
      if (csr_valid && csr_ready) begin
         type_limit_in = csr_data;
      end
      if (report_we) begin
         write_ptr_in = owfpp_pkg::ptr_next(write_ptr_ff);
         // full ring: the new beat replaces the oldest entry
         if (ring_full) begin
            read_ptr_in = owfpp_pkg::ptr_next(read_ptr_ff);
         end else begin
            fill_count_in = fill_count_ff + 1'b1;
         end
      end
      if (pick_re) begin
         read_ptr_in   = owfpp_pkg::ptr_next(read_ptr_ff);
         fill_count_in = fill_count_ff - 1'b1;
         seq_in        = seq_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff  <= '0;
         read_ptr_ff   <= '0;
         fill_count_ff <= '0;
         seq_ff        <= '0;
         type_limit_ff <= owfpp_pkg::TYPE_LIMIT_RESET;
         rsp_strobe_ff <= 1'b0;
         rsp_ok_ff     <= 1'b0;
      end else begin
         write_ptr_ff  <= write_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         fill_count_ff <= fill_count_in;
         seq_ff        <= seq_in;
         type_limit_ff <= type_limit_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ok_ff     <= rsp_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_seq_ff <= rsp_seq_in;
   end

   // reports and picks never share an edge, so the read always sees earlier writes
   always_ff @(posedge clock) begin
      if (report_we) begin
         header_mem[write_ptr_ff]  <= hdr_wr;
         reading_mem[write_ptr_ff] <= rdg_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (pick_re) begin
         hdr_rd_ff <= header_mem[read_ptr_ff];
         rdg_rd_ff <= reading_mem[read_ptr_ff];
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         byte_out[k] = rsp_ok_ff ? rdg_rd_ff[k*owfpp_pkg::BYTE_W +: owfpp_pkg::BYTE_W] : '0;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_seq_byte       = rsp_ok_ff ? rsp_seq_ff : '0;
   // header keeps kind and the low mode bits in its top byte, already in packet order
   assign rsp_kind_mode_byte = rsp_ok_ff ? hdr_rd_ff[owfpp_pkg::HDR_W-1 -: owfpp_pkg::BYTE_W] : '0;
   assign rsp_ident_byte     = rsp_ok_ff ? hdr_rd_ff[owfpp_pkg::IDENT_W-1:0] : '0;
   assign rsp_a_low          = byte_out[0];
   assign rsp_a_high         = byte_out[1];
   assign rsp_b_low          = byte_out[2];
   assign rsp_b_high         = byte_out[3];
   assign rsp_c_low          = byte_out[4];
   assign rsp_c_high         = byte_out[5];
   assign rsp_d_low          = byte_out[6];
   assign rsp_d_high         = byte_out[7];

endmodule

`default_nettype wire

// File: rtl/owfpp_checker.sv
// owfpp_checker: port-level checks on the packet packer, attached by bind
// depends on owfpp_pkg (op codes, field widths) and the top level's ports
`default_nettype none

module owfpp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           req_op,
   input wire logic                           rsp_strobe,
   input wire logic                           rsp_ok,
   input wire logic [owfpp_pkg::BYTE_W-1:0]   rsp_seq_byte,
   input wire logic [owfpp_pkg::BYTE_W-1:0]   rsp_kind_mode_byte,
   input wire logic [owfpp_pkg::BYTE_W-1:0]   rsp_d_high
);

   logic pick_beat;
   logic report_beat;

   assign pick_beat   = start && !busy && (req_op == owfpp_pkg::OP_PICK);
   assign report_beat = start && !busy && (req_op == owfpp_pkg::OP_REPORT);

   a_pick_gives_result: assert property (@(posedge clock) disable iff (reset)
      pick_beat |=> rsp_strobe)
      else $error("pick beat without a result in the next cycle");

   a_result_from_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(pick_beat))
      else $error("result not caused by a pick beat");

   a_report_silent: assert property (@(posedge clock) disable iff (reset)
      report_beat |=> !rsp_strobe)
      else $error("report beat produced a result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |->
         (rsp_seq_byte == '0 && rsp_kind_mode_byte == '0 && rsp_d_high == '0))
      else $error("empty pick result carries nonzero bytes");

endmodule

bind overwrite_fifo_packet_packer owfpp_checker u_owfpp_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_op             (req_op),
   .rsp_strobe         (rsp_strobe),
   .rsp_ok             (rsp_ok),
   .rsp_seq_byte       (rsp_seq_byte),
   .rsp_kind_mode_byte (rsp_kind_mode_byte),
   .rsp_d_high         (rsp_d_high)
);

`default_nettype wire
